[rtl/tgd_pkg.sv]
`default_nettype none

package tgd_pkg;

  // Field widths
  localparam int unsigned READ_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned RUN_W  = 2;

  // APB register map: register i at byte address 4*i
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_BASELINE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DBL_WINDOW = 2'd2
  } reg_idx_t;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

  // Register reset values
  localparam logic [READ_W-1:0] BASELINE_RST   = '0;
  localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd1000;
  localparam logic [TIME_W-1:0] DBL_WINDOW_RST = 32'd400;

  // Touches counted before a pair fires
  localparam logic [RUN_W-1:0] RUN_PAIR = 2'd2;
  localparam logic [RUN_W-1:0] RUN_ONE  = 2'd1;

  // Event queue, one entry per poll that produces events
  localparam int unsigned QUE_DEPTH = 2;
  localparam int unsigned QPTR_W    = 1;
  localparam int unsigned QCNT_W    = 2;

  // One queued poll: leading event kind, and whether a double touch follows
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              dbl;
    logic [READ_W-1:0] rd;
    logic [TIME_W-1:0] tm;
  } evt_t;

endpackage

`default_nettype wire

[rtl/touch_gesture_detector.sv]
`default_nettype none

// Channel | Handshake          | Payload
// --------+--------------------+------------------------------------------------
// in      | in_valid/in_stall  | in_reading, in_now_ms
// out     | out_valid/out_stall| out_event_kind, out_event_reading,
//         |                    | out_event_time, out_last
// cfg     | APB psel/penable   | paddr, pwdata, prdata (pready tied high)
//
// A poll is registered on entry and evaluated while it sits in the input register
// and the queue has a free entry; its events land in a two-entry queue. One poll
// per cycle is taken while the queue has room; a poll giving touch plus double
// touch is sent as a touch beat and then a double-touch beat on the single
// output port. Reset is synchronous and restores register defaults and clears
// all gesture state. The input stalls only while the queue is full.
module touch_gesture_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // poll input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tgd_pkg::READ_W-1:0]    in_reading,
  input  wire logic [tgd_pkg::TIME_W-1:0]    in_now_ms,
  // event output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tgd_pkg::KIND_W-1:0]         out_event_kind,
  output logic [tgd_pkg::READ_W-1:0]         out_event_reading,
  output logic [tgd_pkg::TIME_W-1:0]         out_event_time,
  output logic                               out_last,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tgd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [tgd_pkg::DATA_W-1:0]    pwdata,
  output logic [tgd_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  import tgd_pkg::*;

  // Configuration registers
  logic [READ_W-1:0] baseline_r;
  logic [TIME_W-1:0] long_press_r;
  logic [TIME_W-1:0] dbl_window_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // Input register
  logic              in_vld_r;
  logic [READ_W-1:0] in_rd_r;
  logic [TIME_W-1:0] in_now_r;
  logic              in_acc;

  // Gesture state
  logic              was_touched_r, was_touched_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic [TIME_W-1:0] release_time_r, release_time_nxt;
  logic [RUN_W-1:0]  touch_run_r, touch_run_nxt;
  logic              long_fired_r, long_fired_nxt;

  // Evaluation
  logic              proc;
  logic              touched;
  logic [19:0]       rd_plus1;
  logic [19:0]       rd_x10;
  logic [19:0]       base_x7;
  logic [TIME_W-1:0] rel_dt;
  logic [TIME_W-1:0] press_dt;
  logic [RUN_W-1:0]  run_tmp;
  logic              push;
  evt_t              push_evt;

  // Event queue
  evt_t              que_r [QUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              phase_r;
  evt_t              head;
  logic              beat;
  logic              pop;

  // ---------------------------------------------------------------------
  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r   <= BASELINE_RST;
      long_press_r <= LONG_PRESS_RST;
      dbl_window_r <= DBL_WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BASELINE:   baseline_r   <= pwdata[READ_W-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[TIME_W-1:0];
        REG_DBL_WINDOW: dbl_window_r <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASELINE:   prdata = {{(DATA_W-READ_W){1'b0}}, baseline_r};
      REG_LONG_PRESS: prdata = long_press_r;
      REG_DBL_WINDOW: prdata = dbl_window_r;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register; a poll leaves it when the queue has a free entry
  assign proc     = in_vld_r && (cnt_r != QCNT_W'(QUE_DEPTH));
  assign in_stall = in_vld_r && (cnt_r == QCNT_W'(QUE_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_rd_r  <= in_reading;
      in_now_r <= in_now_ms;
    end
  end

  // ---------------------------------------------------------------------
  // Touch test: rd < floor(70*b/100)  <=>  10*(rd+1) <= 7*b
  assign rd_plus1 = {4'd0, in_rd_r} + 20'd1;
  assign rd_x10   = (rd_plus1 << 3) + (rd_plus1 << 1);
  assign base_x7  = ({4'd0, baseline_r} << 3) - {4'd0, baseline_r};
  assign touched  = rd_x10 <= base_x7;

  // Wrapped time differences
  assign rel_dt   = in_now_r - release_time_r;
  assign press_dt = in_now_r - press_start_r;

  // Gesture decision and state update
  always_comb begin
    was_touched_nxt  = was_touched_r;
    press_start_nxt  = press_start_r;
    release_time_nxt = release_time_r;
    touch_run_nxt    = touch_run_r;
    long_fired_nxt   = long_fired_r;
    run_tmp          = touch_run_r;
    push             = 1'b0;
    push_evt.kind    = KIND_TOUCH;
    push_evt.dbl     = 1'b0;
    push_evt.rd      = in_rd_r;
    push_evt.tm      = in_now_r;

    if (proc) begin
      was_touched_nxt = touched;
      if (touched) begin
        if (!was_touched_r) begin
          // start of a touch
          press_start_nxt = in_now_r;
          long_fired_nxt  = 1'b0;
          run_tmp         = (rel_dt < dbl_window_r) ? touch_run_r + RUN_ONE : RUN_ONE;
          push            = 1'b1;
          if (run_tmp == RUN_PAIR) begin
            push_evt.dbl  = 1'b1;
            touch_run_nxt = '0;
          end else begin
            touch_run_nxt = run_tmp;
          end
        end else if (!long_fired_r && (press_dt > long_press_r)) begin
          // held long enough
          long_fired_nxt = 1'b1;
          push           = 1'b1;
          push_evt.kind  = KIND_LONG;
        end
      end else if (was_touched_r) begin
        release_time_nxt = in_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_touched_r  <= 1'b0;
      press_start_r  <= '0;
      release_time_r <= '0;
      touch_run_r    <= '0;
      long_fired_r   <= 1'b0;
    end else begin
      was_touched_r  <= was_touched_nxt;
      press_start_r  <= press_start_nxt;
      release_time_r <= release_time_nxt;
      touch_run_r    <= touch_run_nxt;
      long_fired_r   <= long_fired_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Event queue; phase_r picks the double-touch beat of a paired entry
  assign head              = que_r[rd_ptr_r];
  assign out_valid         = cnt_r != '0;
  assign out_event_kind    = phase_r ? KIND_DOUBLE : head.kind;
  assign out_event_reading = head.rd;
  assign out_event_time    = head.tm;
  assign out_last          = phase_r || !head.dbl;

  assign beat    = out_valid && !out_stall;
  assign pop     = beat && out_last;
  assign cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        phase_r  <= 1'b0;
      end else if (beat) begin
        phase_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      que_r[wr_ptr_r] <= push_evt;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUE_DEPTH))
    else $error("event queue overfilled");

  a_not_last_is_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_event_kind == KIND_TOUCH))
    else $error("non-final beat is not a touch event");

  // a double touch follows its touch beat, or is itself held by a stall
  a_double_after_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == KIND_DOUBLE) |->
      $past(out_valid && (out_stall || !out_last)))
    else $error("double touch not preceded by its touch beat");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !in_stall)
    else $error("input stalled with empty queue");

endmodule

`default_nettype wire
